>>> design/iotcp_pkg.sv
`default_nettype none
package iotcp_pkg;

	typedef struct packed {
		logic               action;
		logic [7:0]         write_data;
		logic signed [15:0] accel_x;
		logic signed [15:0] accel_y;
		logic signed [15:0] accel_z;
		logic [12:0]        slider_level;
		logic [7:0]         battery_voltage;
		logic [7:0]         battery_level;
		logic [1:0]         wifi_level;
		logic [15:0]        heap_free_kb;
		logic [6:0]         cpu_limit;
	} in_t;

	typedef struct packed {
		logic [15:0] read_data;
		logic        no_device;
		logic [7:0]  led_brightness;
		logic        led_write;
		logic        power_led_on;
		logic        power_led_write;
	} out_t;

	typedef struct packed {
		logic       enable;
		logic [1:0] i2c_a_device;
		logic       analog_led_enable;
	} cfg_t;

	localparam logic [1:0] REG_ENABLE     = 2'd0;
	localparam logic [1:0] REG_I2C_A_DEV  = 2'd1;
	localparam logic [1:0] REG_ANALOG_LED = 2'd2;

	localparam logic [3:0] MODE_NONE    = 4'd0;
	localparam logic [3:0] MODE_ACCEL_X = 4'd1;
	localparam logic [3:0] MODE_ACCEL_Y = 4'd2;
	localparam logic [3:0] MODE_ACCEL_Z = 4'd3;
	localparam logic [3:0] MODE_ANALOG  = 4'd4;
	localparam logic [3:0] MODE_FIND_I  = 4'd6;
	localparam logic [3:0] MODE_FIND_A  = 4'd7;
	localparam logic [3:0] MODE_BAT_CUR = 4'd8;
	localparam logic [3:0] MODE_BAT_LVL = 4'd9;
	localparam logic [3:0] MODE_WIFI    = 4'd10;
	localparam logic [3:0] MODE_HEAP    = 4'd11;
	localparam logic [3:0] MODE_I2C_I   = 4'd12;
	localparam logic [3:0] MODE_CPU     = 4'd13;

	localparam logic [7:0] FRAME_START = 8'hE0;
	localparam logic [7:0] NO_DEVICE   = 8'hFF;

	function automatic logic [7:0] name_byte(input logic [3:0] pos);
		logic [7:0] r;
		case (pos)
			4'd1, 4'd7: r = 8'h30;
			4'd2, 4'd8, 4'd14: r = 8'h38;
			4'd4: r = 8'h33;
			4'd5: r = 8'h34;
			4'd10: r = 8'h35;
			4'd11: r = 8'h31;
			4'd13: r = 8'h36;
			default: r = 8'h00;
		endcase
		return r;
	endfunction

endpackage
`default_nettype wire

>>> design/iotcp_engine.sv
`default_nettype none
module iotcp_engine #(
	parameter int BUFFER_BYTES = 32,
	parameter int WPW = $clog2(BUFFER_BYTES + 1)
) (
	input  wire iotcp_pkg::in_t  req,
	input  wire iotcp_pkg::cfg_t cfg,
	input  wire logic [7:0]      buf_q [BUFFER_BYTES],
	input  wire logic [WPW-1:0]  wp_q,
	input  wire logic [3:0]      mode_q,
	input  wire logic [3:0]      rp_q,
	input  wire logic [7:0]      put_rem_q,
	input  wire logic [7:0]      i2c_q,
	output logic [7:0]           buf_d [BUFFER_BYTES],
	output logic [WPW-1:0]       wp_d,
	output logic [3:0]           mode_d,
	output logic [3:0]           rp_d,
	output logic [7:0]           put_rem_d,
	output logic [7:0]           i2c_d,
	output iotcp_pkg::out_t      res
);
	localparam int IW = $clog2(BUFFER_BYTES);

	function automatic logic has_s(input int off, input logic [63:0] s, input int n);
		logic ok;
		ok = 1'b1;
		for (int i = 0; i < 8; i++) begin
			if (i < n) begin
				if (buf_q[off+i] != s[8*(n-1-i) +: 8])
					ok = 1'b0;
			end
		end
		return ok;
	endfunction

	logic [3:0] get_mode, find_mode;
	logic [3:0] b2hi;
	logic [7:0] v;
	logic put, st, clr;
	logic [15:0] val;
	logic use_reply;
	logic [1:0] dev;

	assign b2hi = buf_q[2][7:4];
	assign v = req.write_data;

	always_comb begin
		get_mode = iotcp_pkg::MODE_NONE;
		if (has_s(5, "device", 6)) begin
			if (has_s(12, "accel", 5) && buf_q[18] == 8'h78)
				get_mode = iotcp_pkg::MODE_ACCEL_X;
			else if (has_s(12, "accel", 5) && buf_q[18] == 8'h79)
				get_mode = iotcp_pkg::MODE_ACCEL_Y;
			else if (has_s(12, "accel", 5) && buf_q[18] == 8'h7A)
				get_mode = iotcp_pkg::MODE_ACCEL_Z;
			else if (has_s(12, "analog", 6) && has_s(19, "in", 2))
				get_mode = iotcp_pkg::MODE_ANALOG;
			else if (has_s(12, "i2c_i", 5))
				get_mode = iotcp_pkg::MODE_I2C_I;
		end else if (has_s(5, "host", 4)) begin
			if (has_s(10, "battery", 7) && has_s(18, "current", 7))
				get_mode = iotcp_pkg::MODE_BAT_CUR;
			else if (has_s(10, "battery", 7) && has_s(18, "level", 5))
				get_mode = iotcp_pkg::MODE_BAT_LVL;
			else if (has_s(10, "wifi", 4) && has_s(15, "level", 5))
				get_mode = iotcp_pkg::MODE_WIFI;
			else if (has_s(10, "heap", 4))
				get_mode = iotcp_pkg::MODE_HEAP;
		end else if (has_s(5, "msx", 3) && has_s(15, "cpu", 3) && has_s(19, "load", 4)) begin
			get_mode = iotcp_pkg::MODE_CPU;
		end
		find_mode = iotcp_pkg::MODE_NONE;
		if (has_s(5, "device", 6) && has_s(12, "i2c_", 4)) begin
			if (buf_q[16] == 8'h69)
				find_mode = iotcp_pkg::MODE_FIND_I;
			else if (buf_q[16] == 8'h61)
				find_mode = iotcp_pkg::MODE_FIND_A;
		end
	end

	always_comb begin
		buf_d = buf_q;
		wp_d = wp_q;
		mode_d = mode_q;
		rp_d = rp_q;
		put_rem_d = put_rem_q;
		i2c_d = i2c_q;
		res = '0;
		st = 1'b0;
		clr = 1'b0;
		val = '0;
		use_reply = 1'b0;
		dev = '0;
		put = (buf_q[2][7:4] == 4'h4) && (buf_q[3][7:4] == 4'hC);
		if (!req.action) begin
			if (cfg.enable) begin
				if (v == iotcp_pkg::FRAME_START) begin
					buf_d[0] = iotcp_pkg::FRAME_START;
					wp_d = WPW'(1);
				end else if (put_rem_q != 8'd0 && put) begin
					put_rem_d = put_rem_q - 8'd1;
					st = 1'b1;
				end else begin
					put_rem_d = 8'd0;
					if (wp_q == WPW'(3)) begin
						buf_d[3] = v;
						if (v == 8'h80 && b2hi == 4'h0) begin
							mode_d = get_mode;
							wp_d = '0;
						end else if (v == 8'h80 && b2hi == 4'h1) begin
							mode_d = find_mode;
							wp_d = '0;
						end else begin
							st = 1'b1;
						end
					end else if (wp_q == WPW'(4)) begin
						if (put)
							put_rem_d = v;
						st = 1'b1;
					end else if (wp_q == WPW'(6) && b2hi == 4'h4
							&& has_s(12, "analog", 6)) begin
						if (has_s(19, "out", 3)) begin
							if (cfg.analog_led_enable) begin
								res.led_brightness = {v[3:0], buf_q[5][7:4]};
								res.led_write = 1'b1;
							end
							wp_d = '0;
						end else begin
							st = 1'b1;
						end
					end else if (wp_q == WPW'(6) && b2hi == 4'h4 && buf_q[5] == 8'h94) begin
						i2c_d = v;
						res.power_led_on = ~v[1];
						res.power_led_write = 1'b1;
						wp_d = '0;
					end else begin
						st = 1'b1;
					end
				end
				if (st && wp_q < WPW'(BUFFER_BYTES)) begin
					buf_d[wp_q[IW-1:0]] = v;
					wp_d = wp_q + WPW'(1);
				end
			end
		end else if (!cfg.enable || buf_q[0] != iotcp_pkg::FRAME_START || buf_q[3] != 8'h80) begin
			res.read_data = {8'h00, iotcp_pkg::NO_DEVICE};
			res.no_device = 1'b1;
		end else begin
			res.read_data = {8'h00, iotcp_pkg::NO_DEVICE};
			res.no_device = 1'b1;
			if (b2hi == 4'h0) begin
				use_reply = 1'b1;
				case (mode_q)
					iotcp_pkg::MODE_ACCEL_X: val = req.accel_y >>> 2;
					iotcp_pkg::MODE_ACCEL_Y: val = req.accel_x >>> 2;
					iotcp_pkg::MODE_ACCEL_Z: val = req.accel_z >>> 2;
					iotcp_pkg::MODE_ANALOG:
						val = (req.slider_level > 13'd4095) ? 16'd4095 : {3'b000, req.slider_level};
					iotcp_pkg::MODE_BAT_CUR: begin
						i2c_d = req.battery_voltage;
						val = {8'h00, req.battery_voltage};
					end
					iotcp_pkg::MODE_BAT_LVL: begin
						i2c_d = req.battery_level;
						val = {8'h00, req.battery_level};
					end
					iotcp_pkg::MODE_WIFI: val = {14'd0, req.wifi_level};
					iotcp_pkg::MODE_HEAP: begin
						use_reply = 1'b0;
						res.read_data = req.heap_free_kb;
						res.no_device = 1'b0;
					end
					iotcp_pkg::MODE_I2C_I: val = {8'h00, i2c_q};
					iotcp_pkg::MODE_CPU: val = {9'd0, req.cpu_limit};
					default: use_reply = 1'b0;
				endcase
				if (use_reply) begin
					res.no_device = 1'b0;
					case (rp_q)
						4'd0: begin
							rp_d = 4'd1;
							res.read_data = 16'd2;
						end
						4'd1: begin
							rp_d = 4'd2;
							res.read_data = {8'h00, val[7:0]};
						end
						4'd2: begin
							rp_d = 4'd0;
							clr = 1'b1;
							res.read_data = {8'h00, val[15:8]};
						end
						default: res.read_data = '0;
					endcase
				end
			end else if (b2hi == 4'h1 && buf_q[2][3:0] == 4'h1) begin
				if (rp_q < 4'd2) begin
					rp_d = rp_q + 4'd1;
					res.read_data = '0;
					res.no_device = 1'b0;
				end else if (rp_q == 4'd2) begin
					if (mode_q == iotcp_pkg::MODE_FIND_I)
						res.read_data = 16'd5;
					else if (mode_q == iotcp_pkg::MODE_FIND_A)
						res.read_data = {15'd0, cfg.i2c_a_device != 2'd0};
					else
						res.read_data = '0;
					res.no_device = 1'b0;
					rp_d = 4'd0;
					clr = 1'b1;
				end
			end else if (b2hi == 4'h1 && buf_q[2][3:0] == 4'h3) begin
				res.no_device = 1'b0;
				res.read_data = '0;
				if (mode_q == iotcp_pkg::MODE_FIND_I) begin
					if (rp_q < 4'd14) begin
						res.read_data = {8'h00, iotcp_pkg::name_byte(rp_q)};
						rp_d = rp_q + 4'd1;
					end else if (rp_q == 4'd14) begin
						rp_d = 4'd0;
						clr = 1'b1;
						res.read_data = 16'h0038;
					end
				end else begin
					dev = (mode_q == iotcp_pkg::MODE_FIND_A) ? cfg.i2c_a_device : 2'd0;
					if (rp_q == 4'd0) begin
						rp_d = 4'd1;
					end else if (rp_q == 4'd1 && dev == 2'd1) begin
						rp_d = 4'd2;
						res.read_data = 16'h0034;
					end else if (rp_q == 4'd1 && dev == 2'd2) begin
						rp_d = 4'd2;
						res.read_data = 16'h0033;
					end else if (rp_q == 4'd1 || rp_q == 4'd2) begin
						// position 1 without a device carries on into the end-of-string step
						rp_d = 4'd0;
						clr = 1'b1;
						if (dev == 2'd1)
							res.read_data = 16'h0030;
						else if (dev == 2'd2)
							res.read_data = 16'h0045;
					end
				end
			end
			if (clr) begin
				for (int i = 0; i < BUFFER_BYTES; i++)
					buf_d[i] = 8'h00;
				wp_d = '0;
				mode_d = iotcp_pkg::MODE_NONE;
				put_rem_d = 8'd0;
			end
		end
	end

endmodule
`default_nettype wire

>>> design/iot_command_port_core.sv
// IoT command port.
// Requests enter on in_valid/in_ready with an iotcp_pkg::in_t payload: a
// write pushes a command byte into the frame buffer, a read returns the next
// reply byte. Every accepted request yields exactly one result on
// out_valid/out_ready in the next cycle, from a result register. A new request can be
// taken every cycle: the frame state is updated in a single pass of logic
// between the state registers and the result register, so throughput is one
// request per cycle while the receiver keeps up.
// If the receiver stalls, the result register holds and in_ready drops until
// the result is taken; no result is lost or repeated.
// Configuration (enable, i2c_a_device, analog_led_enable) is written through
// cfg_valid/cfg_ready/cfg_index/cfg_data; cfg_ready is always high and writes
// are only to be issued while the port is idle.
// Reset (arst_n low) clears the frame buffer, positions and mode, disables
// the port and sets i2c_a_device to 1.
`default_nettype none
module iot_command_port_core #(
	parameter int BUFFER_BYTES = 32
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	output logic                 in_ready,
	input  wire iotcp_pkg::in_t  in_data,
	output logic                 out_valid,
	input  wire logic            out_ready,
	output iotcp_pkg::out_t      out_data,
	input  wire logic            cfg_valid,
	output logic                 cfg_ready,
	input  wire logic [1:0]      cfg_index,
	input  wire logic [1:0]      cfg_data
);
	localparam int WPW = $clog2(BUFFER_BYTES + 1);

	logic [7:0]      buf_q [BUFFER_BYTES];
	logic [7:0]      buf_d [BUFFER_BYTES];
	logic [WPW-1:0]  wp_q, wp_d;
	logic [3:0]      mode_q, mode_d, rp_q, rp_d;
	logic [7:0]      put_rem_q, put_rem_d, i2c_q, i2c_d;
	iotcp_pkg::cfg_t cfg_q;
	iotcp_pkg::out_t res, out_q;
	logic            out_valid_q, accept;

	assign in_ready = !out_valid_q || out_ready;
	assign accept = in_valid && in_ready;
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign out_data = out_q;

	iotcp_engine #(.BUFFER_BYTES(BUFFER_BYTES), .WPW(WPW)) u_engine (
		.req(in_data), .cfg(cfg_q), .buf_q(buf_q), .wp_q(wp_q), .mode_q(mode_q),
		.rp_q(rp_q), .put_rem_q(put_rem_q), .i2c_q(i2c_q), .buf_d(buf_d),
		.wp_d(wp_d), .mode_d(mode_d), .rp_d(rp_d), .put_rem_d(put_rem_d),
		.i2c_d(i2c_d), .res(res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < BUFFER_BYTES; i++)
				buf_q[i] <= 8'h00;
			wp_q <= '0;
			mode_q <= iotcp_pkg::MODE_NONE;
			rp_q <= '0;
			put_rem_q <= '0;
			i2c_q <= '0;
			out_valid_q <= 1'b0;
			cfg_q.enable <= 1'b0;
			cfg_q.i2c_a_device <= 2'd1;
			cfg_q.analog_led_enable <= 1'b0;
		end else begin
			if (accept) begin
				buf_q <= buf_d;
				wp_q <= wp_d;
				mode_q <= mode_d;
				rp_q <= rp_d;
				put_rem_q <= put_rem_d;
				i2c_q <= i2c_d;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_valid) begin
				unique case (cfg_index)
					iotcp_pkg::REG_ENABLE: cfg_q.enable <= cfg_data[0];
					iotcp_pkg::REG_I2C_A_DEV: cfg_q.i2c_a_device <= cfg_data;
					iotcp_pkg::REG_ANALOG_LED: cfg_q.analog_led_enable <= cfg_data[0];
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept)
			out_q <= res;
	end

endmodule
`default_nettype wire
